>>> rtl/ksae_pkg.sv
// Package: shared types, constants and helpers for the speed/accel estimator.
package ksae_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DT_BITS       = 16;
    localparam int POS_W         = 48;
    localparam int DIV_BITS      = 64;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REINIT,
        ST_P_SPD,
        ST_P_T,
        ST_P_VS1,
        ST_P_VS2,
        ST_S_DEN,
        ST_S_DIV0,
        ST_S_WAIT0,
        ST_S_DIV1,
        ST_S_WAIT1,
        ST_S_Y,
        ST_S_UPD1,
        ST_S_UPD2,
        ST_S_UPD3,
        ST_A_DEN,
        ST_A_DIV0,
        ST_A_WAIT0,
        ST_A_DIV1,
        ST_A_WAIT1,
        ST_A_Y,
        ST_A_UPD1,
        ST_A_UPD2,
        ST_A_UPD3,
        ST_POS,
        ST_OUT
    } ksae_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_REINIT,
        OP_P_SPD,
        OP_P_T,
        OP_P_VS1,
        OP_P_VS2,
        OP_S_DEN,
        OP_S_DIV0,
        OP_S_DIV1,
        OP_S_Y,
        OP_S_UPD1,
        OP_S_UPD2,
        OP_S_UPD3,
        OP_A_DEN,
        OP_A_DIV0,
        OP_A_DIV1,
        OP_A_Y,
        OP_A_UPD1,
        OP_A_UPD2,
        OP_A_UPD3,
        OP_POS
    } ksae_op_t;

    typedef struct packed {
        ksae_op_t op;
    } ksae_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic den_pos;
    } ksae_sts_t;

    localparam logic OPC_UPDATE = 1'b0;
    localparam logic OPC_REINIT = 1'b1;

    localparam logic [1:0] REG_PNOISE = 2'd0;
    localparam logic [1:0] REG_SNOISE = 2'd1;
    localparam logic [1:0] REG_ANOISE = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7FFFFFFF;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd140737488355327;
        lo = -66'sd140737488355328;
        if (v > hi)
            sat48 = 48'sh7FFFFFFFFFFF;
        else if (v < lo)
            sat48 = 48'sh800000000000;
        else
            sat48 = v[47:0];
    endfunction

endpackage

>>> rtl/ksae_divider.sv
// Sequential restoring divider, one quotient bit per cycle, truncating toward zero.
module ksae_divider
    import ksae_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [DIV_BITS-1:0] num,
    input  logic        [32:0]         den,
    output logic                       busy,
    output logic signed [DIV_BITS-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] q_reg, q_next;
    logic [33:0]         r_reg, r_next;
    logic [32:0]         d_reg;
    logic                neg_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [33:0]         trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[32:0], q_reg[DIV_BITS-1]};
        if (start)
        begin
            q_next    = num[DIV_BITS-1] ? (~num + 1'b1) : num;
            r_next    = '0;
            cnt_next  = CNT_W'(DIV_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg   <= den;
            neg_reg <= num[DIV_BITS-1];
        end
    end

    assign busy = busy_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

>>> rtl/ksae_datapath.sv
// Datapath: estimate and covariance registers, multiply steps, shared divider.
module ksae_datapath
    import ksae_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ksae_cmd_t               cmd,
    output ksae_sts_t               sts,
    input  logic                    load,
    input  logic signed [31:0]      speed_meas,
    input  logic signed [31:0]      accel_meas,
    input  logic        [15:0]      time_step,
    input  logic        [31:0]      drift_noise,
    input  logic        [31:0]      speed_noise,
    input  logic        [31:0]      accel_noise,
    output logic signed [31:0]      speed_out,
    output logic signed [31:0]      accel_out,
    output logic signed [POS_W-1:0] position_out
);

    localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0]      spd_reg, spd_next;
    logic signed [31:0]      acc_reg, acc_next;
    logic signed [POS_W-1:0] pos_reg, pos_next;
    logic signed [31:0]      va_reg, va_next;
    logic signed [31:0]      cb_reg, cb_next;
    logic signed [31:0]      vc_reg, vc_next;
    logic signed [31:0]      zs_reg, za_reg;
    logic        [15:0]      dt_reg;
    logic signed [65:0]      acc66_reg, acc66_next;
    logic signed [31:0]      k0_reg, k0_next;
    logic signed [31:0]      k1_reg, k1_next;
    logic signed [31:0]      y_reg, y_next;
    logic        [32:0]      den_reg, den_next;
    logic                    denpos_reg, denpos_next;

    // t = cb + dmul(vc,dt) fits in 34 bits; its dt product is taken at full width
    logic signed [33:0]      t_full_reg;
    logic signed [50:0]      tprod;
    logic signed [65:0]      tmul_full;

    logic                    div_start;
    logic signed [DIV_BITS-1:0] div_num;
    logic signed [DIV_BITS-1:0] div_q;
    logic                    div_busy;

    ksae_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .busy  (div_busy),
        .quot  (div_q)
    );

    function automatic logic signed [65:0] dmul(input logic signed [31:0] a,
                                                input logic [15:0] d);
        logic signed [49:0] p;
        p = a * $signed({1'b0, d});
        dmul = 66'(p >>> DT_BITS);
    endfunction

    function automatic logic signed [65:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        fmul = 66'(p >>> FRAC_BITS);
    endfunction

    logic signed [65:0] den_full;

    assign tprod     = t_full_reg * $signed({1'b0, dt_reg});
    assign tmul_full = 66'(tprod >>> DT_BITS);

    always_comb
    begin
        spd_next    = spd_reg;
        acc_next    = acc_reg;
        pos_next    = pos_reg;
        va_next     = va_reg;
        cb_next     = cb_reg;
        vc_next     = vc_reg;
        acc66_next  = acc66_reg;
        k0_next     = k0_reg;
        k1_next     = k1_reg;
        y_next      = y_reg;
        den_next    = den_reg;
        denpos_next = denpos_reg;
        div_start   = 1'b0;
        div_num     = '0;
        den_full    = '0;
        unique case (cmd.op)
            OP_REINIT:
            begin
                spd_next = '0;
                acc_next = '0;
                pos_next = '0;
                va_next  = ONE_FX;
                cb_next  = '0;
                vc_next  = ONE_FX;
            end
            OP_P_SPD:
            begin
                spd_next = sat32(66'(spd_reg) + dmul(acc_reg, dt_reg));
                acc66_next = 66'(cb_reg) + dmul(vc_reg, dt_reg);
            end
            OP_P_T:
            begin
                acc66_next = 66'(va_reg) + dmul(cb_reg, dt_reg)
                           + $signed({34'd0, drift_noise});
            end
            OP_P_VS1:
            begin
                // t may exceed 32 bits; split dmul of the full t
                acc66_next = acc66_reg + tmul_full;
                cb_next    = sat32(66'(t_full_reg));
            end
            OP_P_VS2:
            begin
                va_next = sat32(acc66_reg);
                vc_next = sat32(66'(vc_reg) + $signed({34'd0, drift_noise}));
            end
            OP_S_DEN, OP_A_DEN:
            begin
                den_full = (cmd.op == OP_S_DEN)
                         ? 66'(va_reg) + $signed({34'd0, speed_noise})
                         : 66'(vc_reg) + $signed({34'd0, accel_noise});
                denpos_next = den_full > 0;
                den_next    = den_full[32:0];
            end
            OP_S_DIV0:
            begin
                div_start = 1'b1;
                div_num   = DIV_BITS'(va_reg) <<< FRAC_BITS;
            end
            OP_S_DIV1:
            begin
                k0_next   = sat32(66'(div_q));
                div_start = 1'b1;
                div_num   = DIV_BITS'(cb_reg) <<< FRAC_BITS;
            end
            OP_A_DIV0:
            begin
                div_start = 1'b1;
                div_num   = DIV_BITS'(cb_reg) <<< FRAC_BITS;
            end
            OP_A_DIV1:
            begin
                k0_next   = sat32(66'(div_q));
                div_start = 1'b1;
                div_num   = DIV_BITS'(vc_reg) <<< FRAC_BITS;
            end
            OP_S_Y:
            begin
                k1_next = sat32(66'(div_q));
                y_next  = sat32(66'(zs_reg) - 66'(spd_reg));
            end
            OP_A_Y:
            begin
                k1_next = sat32(66'(div_q));
                y_next  = sat32(66'(za_reg) - 66'(acc_reg));
            end
            OP_S_UPD1, OP_A_UPD1:
            begin
                spd_next = sat32(66'(spd_reg) + fmul(k0_reg, y_reg));
                acc_next = sat32(66'(acc_reg) + fmul(k1_reg, y_reg));
            end
            OP_S_UPD2:
            begin
                va_next = sat32(66'(va_reg) - fmul(k0_reg, va_reg));
                vc_next = sat32(66'(vc_reg) - fmul(k1_reg, cb_reg));
            end
            OP_S_UPD3:
            begin
                cb_next = sat32(66'(cb_reg) - fmul(k0_reg, cb_reg));
            end
            OP_A_UPD2:
            begin
                va_next = sat32(66'(va_reg) - fmul(k0_reg, cb_reg));
                cb_next = sat32(66'(cb_reg) - fmul(k0_reg, vc_reg));
            end
            OP_A_UPD3:
            begin
                vc_next = sat32(66'(vc_reg) - fmul(k1_reg, vc_reg));
            end
            OP_POS:
            begin
                pos_next = sat48(66'(pos_reg) + dmul(spd_reg, dt_reg));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_reg    <= '0;
            acc_reg    <= '0;
            pos_reg    <= '0;
            va_reg     <= ONE_FX;
            cb_reg     <= '0;
            vc_reg     <= ONE_FX;
            denpos_reg <= 1'b0;
        end
        else
        begin
            spd_reg    <= spd_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            va_reg     <= va_next;
            cb_reg     <= cb_next;
            vc_reg     <= vc_next;
            denpos_reg <= denpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc66_reg <= acc66_next;
        k0_reg    <= k0_next;
        k1_reg    <= k1_next;
        y_reg     <= y_next;
        den_reg   <= den_next;
        if (cmd.op == OP_P_SPD)
            t_full_reg <= acc66_next[33:0];
        if (load)
        begin
            zs_reg <= speed_meas;
            za_reg <= accel_meas;
            dt_reg <= time_step;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.den_pos  = denpos_reg;
    assign speed_out    = spd_reg;
    assign accel_out    = acc_reg;
    assign position_out = pos_reg;

endmodule

>>> rtl/ksae_controller.sv
// Controller: sequences prediction, two corrections and position update per update item, or a reinitialize.
module ksae_controller
    import ksae_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      in_opcode,
    input  logic      out_fire,
    input  ksae_sts_t sts,
    output ksae_cmd_t cmd,
    output logic      in_ready,
    output logic      out_valid
);

    ksae_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                    state_next = (in_opcode == OPC_REINIT) ? ST_REINIT : ST_P_SPD;
            end
            ST_REINIT:  begin cmd.op = OP_REINIT; state_next = ST_OUT; end
            ST_P_SPD:   begin cmd.op = OP_P_SPD;  state_next = ST_P_T; end
            ST_P_T:     begin cmd.op = OP_P_T;    state_next = ST_P_VS1; end
            ST_P_VS1:   begin cmd.op = OP_P_VS1;  state_next = ST_P_VS2; end
            ST_P_VS2:   begin cmd.op = OP_P_VS2;  state_next = ST_S_DEN; end
            ST_S_DEN:   begin cmd.op = OP_S_DEN;  state_next = ST_S_DIV0; end
            ST_S_DIV0:
            begin
                if (sts.den_pos)
                begin
                    cmd.op     = OP_S_DIV0;
                    state_next = ST_S_WAIT0;
                end
                else
                    state_next = ST_A_DEN;
            end
            ST_S_WAIT0: if (!sts.div_busy) state_next = ST_S_DIV1;
            ST_S_DIV1:  begin cmd.op = OP_S_DIV1; state_next = ST_S_WAIT1; end
            ST_S_WAIT1: if (!sts.div_busy) state_next = ST_S_Y;
            ST_S_Y:     begin cmd.op = OP_S_Y;    state_next = ST_S_UPD1; end
            ST_S_UPD1:  begin cmd.op = OP_S_UPD1; state_next = ST_S_UPD2; end
            ST_S_UPD2:  begin cmd.op = OP_S_UPD2; state_next = ST_S_UPD3; end
            ST_S_UPD3:  begin cmd.op = OP_S_UPD3; state_next = ST_A_DEN; end
            ST_A_DEN:   begin cmd.op = OP_A_DEN;  state_next = ST_A_DIV0; end
            ST_A_DIV0:
            begin
                if (sts.den_pos)
                begin
                    cmd.op     = OP_A_DIV0;
                    state_next = ST_A_WAIT0;
                end
                else
                    state_next = ST_POS;
            end
            ST_A_WAIT0: if (!sts.div_busy) state_next = ST_A_DIV1;
            ST_A_DIV1:  begin cmd.op = OP_A_DIV1; state_next = ST_A_WAIT1; end
            ST_A_WAIT1: if (!sts.div_busy) state_next = ST_A_Y;
            ST_A_Y:     begin cmd.op = OP_A_Y;    state_next = ST_A_UPD1; end
            ST_A_UPD1:  begin cmd.op = OP_A_UPD1; state_next = ST_A_UPD2; end
            ST_A_UPD2:  begin cmd.op = OP_A_UPD2; state_next = ST_A_UPD3; end
            ST_A_UPD3:  begin cmd.op = OP_A_UPD3; state_next = ST_POS; end
            ST_POS:     begin cmd.op = OP_POS;    state_next = ST_OUT; end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/kalman_speed_accel_estimator_unit.sv
// Top level: stream ports, APB register file, controller and datapath.
// Sequence: an update item runs four divisions on the shared radix-2 divider, plus
//   the prediction, update and position steps; a skipped correction saves its two
//   divisions. A reinitialize item only clears the state. The divider dominates the time.
// Flow: one item at a time; the next input transfer can come in the cycle after the
//   result transfer.
// Reset: rst_n async low; estimates zero, covariance identity, noise registers 1.0.
module kalman_speed_accel_estimator_unit
    import ksae_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // speed_meas[31:0], accel_meas[63:32], time_step[79:64]
    input  logic         s_tuser,   // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // speed_out[31:0], accel_out[63:32], position_out[111:64]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [31:0] ONE_CFG = 32'd1 << FRAC_BITS;

    logic [31:0] pnoise_reg, snoise_reg, anoise_reg;
    logic        cfg_wr;
    logic        in_fire, out_fire, in_ready, out_valid;
    ksae_cmd_t   cmd;
    ksae_sts_t   sts;
    logic signed [31:0]      speed_out, accel_out;
    logic signed [POS_W-1:0] position_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pnoise_reg <= ONE_CFG;
            snoise_reg <= ONE_CFG;
            anoise_reg <= ONE_CFG;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[3:2])
                REG_PNOISE: pnoise_reg <= pwdata;
                REG_SNOISE: snoise_reg <= pwdata;
                REG_ANOISE: anoise_reg <= pwdata;
                default:    pnoise_reg <= pnoise_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PNOISE: prdata = pnoise_reg;
            REG_SNOISE: prdata = snoise_reg;
            REG_ANOISE: prdata = anoise_reg;
            default:    prdata = '0;
        endcase
    end

    assign in_fire  = s_tvalid && in_ready;
    assign out_fire = out_valid && m_tready;
    assign s_tready = in_ready;
    assign m_tvalid = out_valid;

    ksae_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_opcode (s_tuser),
        .out_fire  (out_fire),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    ksae_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .load          (in_fire),
        .speed_meas    ($signed(s_tdata[31:0])),
        .accel_meas    ($signed(s_tdata[63:32])),
        .time_step     (s_tdata[79:64]),
        .drift_noise   (pnoise_reg),
        .speed_noise   (snoise_reg),
        .accel_noise   (anoise_reg),
        .speed_out     (speed_out),
        .accel_out     (accel_out),
        .position_out  (position_out)
    );

    assign m_tdata = {position_out, accel_out, speed_out};

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    a_reinit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser) |=> ##1 (m_tvalid && m_tdata == '0))
        else $error("reinitialize did not clear estimates");

    a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("not ready after result transfer");

endmodule

>>> sim/kalman_speed_accel_estimator_unit_checker.sv
// Checker: watches the stream channels and register writes, predicts and compares results.
module kalman_speed_accel_estimator_unit_checker
    import ksae_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [79:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [47:0] position;
        logic signed [31:0] accel;
        logic signed [31:0] speed;
    } estimate_t;

    localparam int FB = FRAC_BITS_DEF;

    estimate_t est_q[$];
    longint spd, acc, pos, vs, vx, va;
    longint q_noise, s_noise, a_noise;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clip48(longint v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    function automatic longint kgain(longint num, longint den);
        return clip32((num * (64'sd1 <<< FB)) / den);
    endfunction

    task automatic clear_state();
        spd = 0; acc = 0; pos = 0;
        vs = 64'sd1 <<< FB; vx = 0; va = 64'sd1 <<< FB;
    endtask

    task automatic predict_estimate(input logic opc, input logic [79:0] d);
        longint zs, za, dt, a, b, c, t, den, k0, k1, y;
        estimate_t e;
        if (opc == OPC_REINIT)
            clear_state();
        else
        begin
            zs = longint'($signed(d[31:0]));
            za = longint'($signed(d[63:32]));
            dt = longint'(d[79:64]);
            spd = clip32(spd + ((acc * dt) >>> DT_BITS));
            a = vs; b = vx; c = va;
            t = b + ((c * dt) >>> DT_BITS);
            vs = clip32(a + ((b * dt) >>> DT_BITS) + ((t * dt) >>> DT_BITS) + q_noise);
            vx = clip32(t);
            va = clip32(c + q_noise);
            a = vs; b = vx; c = va;
            den = a + s_noise;
            if (den > 0)
            begin
                k0 = kgain(a, den);
                k1 = kgain(b, den);
                y = clip32(zs - spd);
                spd = clip32(spd + ((k0 * y) >>> FB));
                acc = clip32(acc + ((k1 * y) >>> FB));
                vs = clip32(a - ((k0 * a) >>> FB));
                vx = clip32(b - ((k0 * b) >>> FB));
                va = clip32(c - ((k1 * b) >>> FB));
            end
            a = vs; b = vx; c = va;
            den = c + a_noise;
            if (den > 0)
            begin
                k0 = kgain(b, den);
                k1 = kgain(c, den);
                y = clip32(za - acc);
                spd = clip32(spd + ((k0 * y) >>> FB));
                acc = clip32(acc + ((k1 * y) >>> FB));
                vs = clip32(a - ((k0 * b) >>> FB));
                vx = clip32(b - ((k0 * c) >>> FB));
                va = clip32(c - ((k1 * c) >>> FB));
            end
            pos = clip48(pos + ((spd * dt) >>> DT_BITS));
        end
        e.speed = spd[31:0];
        e.accel = acc[31:0];
        e.position = pos[47:0];
        est_q.push_back(e);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        estimate_t got, want;
        if (!rst_n)
        begin
            fail_count = 0;
            q_noise = 64'sd1 <<< FB; s_noise = 64'sd1 <<< FB; a_noise = 64'sd1 <<< FB;
            clear_state();
            est_q.delete();
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_PNOISE: q_noise = longint'(pwdata);
                    REG_SNOISE: s_noise = longint'(pwdata);
                    REG_ANOISE: a_noise = longint'(pwdata);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (est_q.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    want = est_q.pop_front();
                    if (got.speed != want.speed)
                        report_mismatch("speed_out", got.speed, want.speed);
                    if (got.accel != want.accel)
                        report_mismatch("accel_out", got.accel, want.accel);
                    if (got.position != want.position)
                        report_mismatch("position_out", got.position, want.position);
                end
            end
            if (s_tvalid && s_tready)
                predict_estimate(s_tuser, s_tdata);
            pending = est_q.size();
        end
    end
endmodule

>>> sim/kalman_speed_accel_estimator_unit_tb.sv
// Testbench top: clock, reset, stimulus, register phases and verdict.
module kalman_speed_accel_estimator_unit_tb
    import ksae_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam longint CYCLE_LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // speed_meas[31:0], accel_meas[63:32], time_step[79:64]
    logic         s_tuser;   // opcode
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;   // speed_out[31:0], accel_out[63:32], position_out[111:64]
    logic         psel, penable, pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    longint       cycles;
    bit           calm;
    bit           hold_req;
    bit           hold_done;

    kalman_speed_accel_estimator_unit i_dut (.*);

    kalman_speed_accel_estimator_unit_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        hold_done = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (1500) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 10);
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic opc, input logic [31:0] zs, input logic [31:0] za,
                             input logic [15:0] dt);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= opc;
        s_tdata <= {dt, za, zs};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_meas();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            default: return $urandom_range(0, 32'h00A00000) - 32'h00500000;
        endcase
    endfunction

    function automatic logic [15:0] rnd_dt();
        case ($urandom_range(0, 5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom());
            default: return 16'($urandom_range(1, 16'h0800));
        endcase
    endfunction

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_item(($urandom_range(0, 40) == 0) ? OPC_REINIT : OPC_UPDATE,
                      rnd_meas(), rnd_meas(), rnd_dt());
    endtask

    initial
    begin
        calm = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, extremes, reinit
        send_item(OPC_UPDATE, 32'h00010000, 32'h00008000, 16'h1000);
        send_item(OPC_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
        send_item(OPC_UPDATE, 32'h80000000, 32'h80000000, 16'hFFFF);
        send_item(OPC_UPDATE, 32'h7FFFFFFF, 32'h80000000, 16'h0000);
        send_item(OPC_UPDATE, 32'hFFFFFFFF, 32'h00000000, 16'h0001);
        send_item(OPC_REINIT, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_item(OPC_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
        drain();

        // zero noise: nonpositive innovation variance paths
        reg_write(REG_PNOISE, 32'h0);
        reg_write(REG_SNOISE, 32'h0);
        reg_write(REG_ANOISE, 32'h0);
        send_item(OPC_REINIT, 32'h0, 32'h0, 16'h0);
        for (int i = 0; i < 6; i++)
            send_item(OPC_UPDATE, rnd_meas(), rnd_meas(), 16'hFFFF);
        drain();

        // maximum noise values
        reg_write(REG_PNOISE, 32'hFFFFFFFF);
        reg_write(REG_SNOISE, 32'hFFFFFFFF);
        reg_write(REG_ANOISE, 32'hFFFFFFFF);
        for (int i = 0; i < 5; i++)
            send_item(OPC_UPDATE, rnd_meas(), rnd_meas(), rnd_dt());
        drain();
        reg_write(REG_PNOISE, 32'h00010000);
        reg_write(REG_SNOISE, 32'h00010000);
        reg_write(REG_ANOISE, 32'h00010000);
        send_item(OPC_REINIT, 32'h0, 32'h0, 16'h0);

        // long receiver hold-off while items keep coming
        hold_req = 1'b1;
        random_phase(RANDOM_ITEMS / 5);
        drain();

        reg_write(REG_PNOISE, $urandom_range(0, 32'h00004000));
        reg_write(REG_SNOISE, $urandom_range(1, 32'h00100000));
        reg_write(REG_ANOISE, $urandom_range(1, 32'h00100000));
        random_phase(RANDOM_ITEMS / 5);
        drain();

        reg_write(REG_PNOISE, $urandom());
        reg_write(REG_SNOISE, $urandom());
        reg_write(REG_ANOISE, $urandom());
        random_phase(RANDOM_ITEMS / 5);
        drain();

        reg_write(REG_PNOISE, 32'h00000100);
        reg_write(REG_SNOISE, 32'h00000001);
        reg_write(REG_ANOISE, 32'h00000001);
        random_phase(RANDOM_ITEMS / 5);
        drain();

        calm = 1'b1;
        reg_write(REG_PNOISE, 32'h00010000);
        reg_write(REG_SNOISE, 32'h00020000);
        reg_write(REG_ANOISE, 32'h00008000);
        random_phase(RANDOM_ITEMS / 5);
        drain();
        repeat (300) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
